@@ rtl/core/fmjg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmjg_pkg
// shared types, codes and reset values for the feeder mode and jam guard
// ----------------------------------------------------------------------------
package fmjg_pkg;

  // switch positions
  localparam logic [1:0] SW_DOWN = 2'd0;
  localparam logic [1:0] SW_MID  = 2'd1;
  localparam logic [1:0] SW_UP   = 2'd2;

  // feeder modes
  localparam logic [1:0] MODE_STOP   = 2'd0;
  localparam logic [1:0] MODE_SINGLE = 2'd1;
  localparam logic [1:0] MODE_BURST  = 2'd2;
  localparam logic [1:0] MODE_JAM    = 2'd3;

  // register indexes
  localparam logic [1:0] CFG_JAM_SPEED_LIMIT = 2'd0;
  localparam logic [1:0] CFG_JAM_TICKS       = 2'd1;
  localparam logic [1:0] CFG_REVERSE_TICKS   = 2'd2;
  localparam logic [1:0] CFG_HOLD_TICKS      = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register reset values
  localparam logic [14:0] RST_JAM_SPEED_LIMIT = 15'd100;
  localparam logic [15:0] RST_JAM_TICKS       = 16'd500;
  localparam logic [15:0] RST_REVERSE_TICKS   = 16'd200;
  localparam logic [15:0] RST_HOLD_TICKS      = 16'd1000;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  typedef struct packed {
    logic [14:0] jam_speed_limit;
    logic [15:0] jam_ticks;
    logic [15:0] reverse_ticks;
    logic [15:0] hold_ticks;
  } fmjg_cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        ready;
    logic        up_last;
    logic [15:0] hold_count;
    logic [15:0] jam_count;
    logic [15:0] reverse_count;
  } fmjg_state_t;

  typedef struct packed {
    logic               move_pending;
    logic signed [15:0] feeder_speed;
    logic               link_offline;
    logic               host_fire;
    logic               host_fric_on;
    logic [1:0]         arm_switch;
    logic [1:0]         mode_switch;
  } fmjg_item_t;

  typedef struct packed {
    logic       clear_move;
    logic       wheel_ready;
    logic [1:0] feed_mode;
  } fmjg_result_t;

endpackage

@@ rtl/core/fmjg_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmjg_cfg
// configuration register bank, write only
// ----------------------------------------------------------------------------
module fmjg_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fmjg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fmjg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output fmjg_pkg::fmjg_cfg_t            cfg_o
);
  import fmjg_pkg::*;

  fmjg_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.jam_speed_limit <= RST_JAM_SPEED_LIMIT;
      cfg_r.jam_ticks       <= RST_JAM_TICKS;
      cfg_r.reverse_ticks   <= RST_REVERSE_TICKS;
      cfg_r.hold_ticks      <= RST_HOLD_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_JAM_SPEED_LIMIT: cfg_r.jam_speed_limit <= cfg_wdata[14:0];
        CFG_JAM_TICKS:       cfg_r.jam_ticks       <= cfg_wdata;
        CFG_REVERSE_TICKS:   cfg_r.reverse_ticks   <= cfg_wdata;
        CFG_HOLD_TICKS:      cfg_r.hold_ticks      <= cfg_wdata;
        default:             cfg_r <= cfg_r;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

@@ rtl/core/fmjg_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmjg_step
// one tick of mode selection and jam guard, purely combinational
// ----------------------------------------------------------------------------
module fmjg_step (
  input  fmjg_pkg::fmjg_cfg_t    cfg_i,
  input  fmjg_pkg::fmjg_state_t  state_i,
  input  fmjg_pkg::fmjg_item_t   item_i,
  output fmjg_pkg::fmjg_state_t  state_o,
  output fmjg_pkg::fmjg_result_t result_o
);
  import fmjg_pkg::*;

  logic [16:0] speed_mag;
  logic        arm_live;
  logic        up;
  logic        clear;
  fmjg_state_t st;

  always_comb begin
    // magnitude in 17 bits so that the most negative speed stays large
    if (item_i.feeder_speed[15]) begin
      speed_mag = 17'd0 - {item_i.feeder_speed[15], item_i.feeder_speed};
    end else begin
      speed_mag = {1'b0, item_i.feeder_speed};
    end
  end

  assign arm_live = (item_i.arm_switch == SW_MID) || (item_i.arm_switch == SW_UP);
  assign up       = (item_i.mode_switch == SW_UP);

  always_comb begin
    st    = state_i;
    clear = 1'b0;

    if (item_i.mode_switch == SW_DOWN) begin
      st.ready = 1'b0;
      st.mode  = MODE_STOP;
    end else if (arm_live) begin
      st.ready = (item_i.arm_switch == SW_MID) ||
                 ((item_i.arm_switch == SW_UP) && item_i.host_fric_on);
      st.mode    = (up && !state_i.up_last) ? MODE_SINGLE : MODE_STOP;
      st.up_last = up;
      if (item_i.arm_switch == SW_UP) begin
        st.mode = item_i.host_fire ? MODE_BURST : MODE_STOP;
      end
      if (item_i.move_pending) begin
        st.mode = MODE_SINGLE;
      end
      if (up) begin
        if (state_i.hold_count < cfg_i.hold_ticks) begin
          st.hold_count = state_i.hold_count + 16'd1;
        end else begin
          st.mode = MODE_BURST;
          clear   = 1'b1;
        end
      end else begin
        st.hold_count = 16'd0;
      end
    end

    // jam guard only while the feeder is meant to move
    if ((st.mode == MODE_BURST) || (st.mode == MODE_SINGLE)) begin
      if (state_i.jam_count >= cfg_i.jam_ticks) begin
        st.mode = MODE_JAM;
      end
      if ((speed_mag < {2'b00, cfg_i.jam_speed_limit}) &&
          (state_i.jam_count < cfg_i.jam_ticks)) begin
        st.jam_count     = state_i.jam_count + 16'd1;
        st.reverse_count = 16'd0;
      end else if ((state_i.jam_count == cfg_i.jam_ticks) &&
                   (state_i.reverse_count < cfg_i.reverse_ticks)) begin
        st.reverse_count = state_i.reverse_count + 16'd1;
      end else begin
        st.jam_count = 16'd0;
      end
    end

    // safe stop
    if ((item_i.arm_switch == SW_DOWN) || item_i.link_offline) begin
      st.mode  = MODE_STOP;
      st.ready = 1'b0;
    end
  end

  assign state_o              = st;
  assign result_o.feed_mode   = st.mode;
  assign result_o.wheel_ready = st.ready;
  assign result_o.clear_move  = clear;

endmodule

@@ rtl/core/feeder_mode_jam_guard.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feeder_mode_jam_guard
// feeder mode selection and jam reverse guard for a friction-wheel launcher
// ----------------------------------------------------------------------------
// usage:
//   one input item per control tick on the in_ stream carries both switch
//   positions, host commands, the link flag, feeder speed and the pending
//   move flag. for each item one result item leaves on the out_ stream with
//   the feeder mode, the friction ready flag and the move cancel flag.
//   an item accepted at an edge is shown on out_ from the next cycle, out of
//   a single output register.
//   throughput is one item per cycle while the receiver keeps up; in_tready
//   stays high while the output register is empty or its item is being
//   taken in the same cycle, so the only other limit is the tick state loop.
//   when the receiver stalls, the result holds in the output register and
//   in_tready drops until it is taken; no item is lost or repeated.
//   the cfg_ port writes the four thresholds at any edge with cfg_we high;
//   write only while no item is in flight.
//   reset (rst_n low, synchronous) puts the tick state to stop, not ready,
//   all counters zero, loads default thresholds and empties the output.
// ----------------------------------------------------------------------------
module feeder_mode_jam_guard (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: mode_switch[1:0], arm_switch[3:2], host_fric_on[4], host_fire[5],
  //           link_offline[6], feeder_speed[22:7], move_pending[23]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [fmjg_pkg::IN_DATA_W-1:0]  in_tdata,
  // out_tdata: feed_mode[1:0], wheel_ready[2], clear_move[3], zeros[7:4]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [fmjg_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic [fmjg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fmjg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import fmjg_pkg::*;

  fmjg_cfg_t    cfg;
  fmjg_item_t   item;
  fmjg_state_t  state_r;
  fmjg_state_t  state_nxt;
  fmjg_result_t result_nxt;
  fmjg_result_t result_r;
  logic         out_valid_r;
  logic         in_fire;

  // threshold registers
  fmjg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // field layout matches the struct order, lowest field in the lowest bits
  assign item = fmjg_item_t'(in_tdata);

  // one tick of decision logic
  fmjg_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_r),
    .item_i   (item),
    .state_o  (state_nxt),
    .result_o (result_nxt)
  );

  // take a new item whenever the output slot is free or drains this cycle
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // tick state advances once per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, result_r};

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the feeder mode and jam guard
// ----------------------------------------------------------------------------
// control ticks are queued by the stimulus process and sent by a clocked
// driver with random gaps. a clocked monitor runs its own tick model on every
// accepted item and checks each result item against the oldest prediction.
// the thresholds are rewritten between phases, only while nothing is in
// flight, and cover the reset values, the extremes and small random settings.
// ----------------------------------------------------------------------------
module tb_top;
  import fmjg_pkg::*;

  logic clk;
  logic rst_n = 1'b0;

  // in_tdata: mode_switch[1:0], arm_switch[3:2], host_fric_on[4], host_fire[5],
  //           link_offline[6], feeder_speed[22:7], move_pending[23]
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  fmjg_item_t in_item   = '0;
  // out_tdata: feed_mode[1:0], wheel_ready[2], clear_move[3], zeros[7:4]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  feeder_mode_jam_guard i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // ticks waiting to be sent, results the block still owes
  fmjg_item_t   tick_q[$];
  fmjg_result_t due_results[$];

  int   mismatches = 0;
  logic in_taken   = 1'b0;  // item accepted at the last rising edge
  logic calm       = 1'b0;  // no idling on either side while set
  int   gen_lim    = 100;   // speed limit the stimulus aims below

  // model copy of the thresholds
  logic [14:0] lim_cfg;
  logic [15:0] jam_cfg;
  logic [15:0] rev_cfg;
  logic [15:0] hold_cfg;

  // model copy of the tick state
  logic [1:0]  tick_mode;
  logic        tick_ready;
  logic        up_last;
  logic [15:0] hold_cnt;
  logic [15:0] jam_cnt;
  logic [15:0] rev_cnt;

  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one control tick of the guard: updates the model state, returns the result
  function automatic fmjg_result_t predict_tick(fmjg_item_t it);
    fmjg_result_t res;
    int           spd;
    int           mag;
    logic         up;
    logic         clr;
    spd = it.feeder_speed;
    mag = (spd < 0) ? -spd : spd;  // -32768 gives 32768, never below the limit
    clr = 1'b0;
    if (it.mode_switch == SW_DOWN) begin
      tick_ready = 1'b0;
      tick_mode  = MODE_STOP;
    end else if (it.arm_switch == SW_MID || it.arm_switch == SW_UP) begin
      // mode switch value three acts like middle
      up         = (it.mode_switch == SW_UP);
      tick_ready = (it.arm_switch == SW_MID) ||
                   (it.arm_switch == SW_UP && it.host_fric_on);
      tick_mode  = (up && !up_last) ? MODE_SINGLE : MODE_STOP;
      up_last    = up;
      if (it.arm_switch == SW_UP) begin
        tick_mode = it.host_fire ? MODE_BURST : MODE_STOP;
      end
      if (it.move_pending) begin
        tick_mode = MODE_SINGLE;
      end
      if (up) begin
        if (hold_cnt < hold_cfg) begin
          hold_cnt = hold_cnt + 16'd1;
        end else begin
          // held long enough: burst, and the pending move is dropped
          tick_mode = MODE_BURST;
          clr       = 1'b1;
        end
      end else begin
        hold_cnt = '0;
      end
    end
    // arm switch value three with the mode switch not down keeps the old mode

    // jam guard only while the feeder is meant to move
    if (tick_mode == MODE_BURST || tick_mode == MODE_SINGLE) begin
      if (jam_cnt >= jam_cfg) begin
        tick_mode = MODE_JAM;
      end
      if (mag < int'(lim_cfg) && jam_cnt < jam_cfg) begin
        jam_cnt = jam_cnt + 16'd1;
        rev_cnt = '0;
      end else if (jam_cnt == jam_cfg && rev_cnt < rev_cfg) begin
        rev_cnt = rev_cnt + 16'd1;
      end else begin
        jam_cnt = '0;
      end
    end

    // link lost or arm down: safe stop, but an earlier cancel still shows
    if (it.arm_switch == SW_DOWN || it.link_offline) begin
      tick_mode  = MODE_STOP;
      tick_ready = 1'b0;
    end
    res.feed_mode   = tick_mode;
    res.wheel_ready = tick_ready;
    res.clear_move  = clr;
    return res;
  endfunction

  task automatic flag_mismatch(string what, fmjg_result_t want, fmjg_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected mode %0d ready %0b clear %0b,",
               $realtime, what, want.feed_mode, want.wheel_ready, want.clear_move,
               " got mode %0d ready %0b clear %0b",
               got.feed_mode, got.wheel_ready, got.clear_move);
    end
  endtask

  // sender: holds an item until taken, otherwise may idle before the next one unless calm
  always @(negedge clk) begin : tick_driver
    logic       nv;
    fmjg_item_t nd;
    nv = in_tvalid;
    nd = in_item;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (!in_tvalid || in_taken) begin
      nv = 1'b0;
      if (tick_q.size() != 0 && (calm || $urandom_range(0, 99) >= 25)) begin
        nd = tick_q.pop_front();
        nv = 1'b1;
      end
    end
    in_tvalid <= nv;
    in_item   <= nd;
  end

  // receiver: stalls about a quarter of the cycles unless calm is set
  always @(negedge clk) begin : result_sink
    out_tready <= rst_n && (calm || $urandom_range(0, 99) >= 25);
  end

  // monitor: config mirror, result check, then prediction for the new item
  always @(posedge clk) begin : tick_monitor
    fmjg_result_t got;
    fmjg_result_t want;
    if (!rst_n) begin
      lim_cfg    = RST_JAM_SPEED_LIMIT;
      jam_cfg    = RST_JAM_TICKS;
      rev_cfg    = RST_REVERSE_TICKS;
      hold_cfg   = RST_HOLD_TICKS;
      tick_mode  = MODE_STOP;
      tick_ready = 1'b0;
      up_last    = 1'b0;
      hold_cnt   = '0;
      jam_cnt    = '0;
      rev_cnt    = '0;
      in_taken   = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_JAM_SPEED_LIMIT: lim_cfg  = cfg_wdata[14:0];
          CFG_JAM_TICKS:       jam_cfg  = cfg_wdata;
          CFG_REVERSE_TICKS:   rev_cfg  = cfg_wdata;
          CFG_HOLD_TICKS:      hold_cfg = cfg_wdata;
          default: ;
        endcase
      end
      // an older result leaves before this edge's item is predicted
      if (out_tvalid && out_tready) begin
        got = out_tdata[3:0];
        if (due_results.size() == 0) begin
          flag_mismatch("result with none due", '0, got);
        end else begin
          want = due_results.pop_front();
          if (got.feed_mode !== want.feed_mode || got.wheel_ready !== want.wheel_ready ||
              got.clear_move !== want.clear_move) begin
            flag_mismatch("result differs", want, got);
          end
        end
      end
      in_taken = in_tvalid && in_tready;
      if (in_taken) begin
        due_results.push_back(predict_tick(in_item));
      end
    end
  end

  function automatic fmjg_item_t tick_of(logic [1:0] msw, logic [1:0] asw, logic fric,
                                         logic fire, logic off, int spd, logic pend);
    fmjg_item_t it;
    it.mode_switch  = msw;
    it.arm_switch   = asw;
    it.host_fric_on = fric;
    it.host_fire    = fire;
    it.link_offline = off;
    it.feeder_speed = 16'(spd);
    it.move_pending = pend;
    return it;
  endfunction

  // thresholds, written one per cycle; the limit gets a random bit 15 to
  // show that it is masked off
  task automatic set_regs(int lim, int jt, int rt, int ht);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_JAM_SPEED_LIMIT;
    cfg_wdata <= {1'($urandom_range(0, 1)), 15'(lim)};
    @(negedge clk);
    cfg_index <= CFG_JAM_TICKS;
    cfg_wdata <= 16'(jt);
    @(negedge clk);
    cfg_index <= CFG_REVERSE_TICKS;
    cfg_wdata <= 16'(rt);
    @(negedge clk);
    cfg_index <= CFG_HOLD_TICKS;
    cfg_wdata <= 16'(ht);
    @(negedge clk);
    cfg_we    <= 1'b0;
    gen_lim = lim;
  endtask

  // wait until nothing is queued, in flight or owed
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (tick_q.size() != 0 || in_tvalid || due_results.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // one run of ticks: mostly a consistent switch pattern with low speed so the
  // hold and jam counters get far, some fully random noise mixed in
  task automatic push_run(inout int made);
    int         n;
    int         m;
    int         shape;
    logic       noisy;
    logic       fire;
    logic [1:0] arm;
    fmjg_item_t it;
    noisy = ($urandom_range(0, 9) == 0);
    n     = $urandom_range(3, 40);
    shape = $urandom_range(0, 2);  // held up, toggling, middle with pending moves
    arm   = $urandom_range(0, 1) ? SW_UP : SW_MID;
    fire  = ($urandom_range(0, 3) != 0);
    for (int k = 0; k < n; k++) begin
      if (noisy || $urandom_range(0, 9) == 0) begin
        it = 24'($urandom);
      end else begin
        if (gen_lim > 0 && $urandom_range(0, 3) != 0) begin
          m = $urandom_range(0, gen_lim - 1);
        end else begin
          m = $urandom_range(0, 32767);
        end
        it.mode_switch  = (shape == 0) ? SW_UP :
                          (shape == 1) ? ($urandom_range(0, 1) ? SW_UP : SW_MID) : SW_MID;
        it.arm_switch   = arm;
        it.host_fric_on = 1'($urandom_range(0, 1));
        it.host_fire    = fire;
        it.link_offline = ($urandom_range(0, 39) == 0);
        it.feeder_speed = 16'($urandom_range(0, 1) ? -m : m);
        it.move_pending = (shape == 2) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) == 0);
      end
      tick_q.push_back(it);
      made++;
    end
  endtask

  initial begin : stimulus
    int made;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed ticks with short thresholds so every mode shows up quickly
    set_regs(100, 2, 3, 3);
    tick_q.push_back(tick_of(SW_DOWN, SW_MID, 0, 0, 0, 0, 0));       // stop
    tick_q.push_back(tick_of(SW_UP,   SW_MID, 0, 0, 0, 500, 0));     // rising edge, single
    tick_q.push_back(tick_of(SW_UP,   SW_MID, 0, 0, 0, 20, 0));
    tick_q.push_back(tick_of(SW_MID,  SW_UP,  1, 1, 0, -32768, 0));  // burst, most negative
    tick_q.push_back(tick_of(SW_MID,  SW_UP,  1, 1, 0, 32767, 0));
    tick_q.push_back(tick_of(SW_MID,  SW_UP,  0, 1, 0, 0, 0));       // low speed ticks
    tick_q.push_back(tick_of(SW_MID,  SW_UP,  0, 1, 0, -1, 0));
    tick_q.push_back(tick_of(SW_MID,  SW_UP,  0, 1, 0, -99, 0));     // jam reverse
    tick_q.push_back(tick_of(SW_MID,  SW_UP,  0, 1, 0, 99, 0));
    tick_q.push_back(tick_of(SW_MID,  2'd3,   1, 1, 0, 100, 0));     // arm three keeps mode
    tick_q.push_back(tick_of(2'd3,    SW_MID, 1, 0, 0, -100, 1));    // mode three, pending
    tick_q.push_back(tick_of(SW_UP,   SW_MID, 0, 0, 1, 0, 1));       // link lost
    tick_q.push_back(tick_of(SW_UP,   SW_DOWN, 1, 1, 0, 0, 0));      // arm down
    for (int k = 0; k < 5; k++) begin
      tick_q.push_back(tick_of(SW_UP, SW_MID, 0, 0, 0, 1000, 0));    // hold past limit
    end
    tick_q.push_back(tick_of(SW_UP,   SW_UP,  1, 0, 1, 5, 1));       // cancel while offline
    tick_q.push_back(tick_of(SW_DOWN, 2'd3,   1, 1, 1, 7, 1));
    tick_q.push_back(tick_of(SW_MID,  SW_MID, 0, 0, 0, 0, 1));       // pending single
    tick_q.push_back(tick_of(SW_UP,   SW_MID, 1, 1, 0, -32767, 0));
    tick_q.push_back(tick_of(SW_MID,  SW_UP,  0, 0, 0, 12345, 0));   // arm up, fric off
    wait_idle();

    // random phases; each boundary pauses the sender until all results are in
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: set_regs(100, 500, 200, 1000);             // reset values
        1: set_regs(32767, 1, 65535, 0);              // hold of zero, widest limit
        2: set_regs(0, 65535, 1, 65535);              // nothing counts as low
        3: set_regs(32767, 0, 1, 1);                  // jam right away
        4: set_regs(32767, 40, 5, 8);
        5: set_regs(32767, 4, 5, 8);                  // lowered below a running count
        default: set_regs($urandom_range(0, 400), $urandom_range(1, 15),
                          $urandom_range(1, 15), $urandom_range(1, 12));
      endcase
      calm = (p == 6);  // one phase with no idling at all
      made = 0;
      while (made < 115) begin
        push_run(made);
      end
      wait_idle();
    end

    calm = 1'b0;
    repeat (10) @(posedge clk);
    if (due_results.size() != 0) begin
      mismatches++;
      $display("%0t: %0d results never arrived", $realtime, due_results.size());
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hard stop far beyond the slowest correct run
  initial begin : watchdog
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ feeder_mode_jam_guard.f @@
rtl/core/fmjg_pkg.sv
rtl/core/fmjg_cfg.sv
rtl/core/fmjg_step.sv
rtl/core/feeder_mode_jam_guard.sv
verif/tb_top.sv
